@@ hw/rtl/jse_pkg.sv @@
package jse_pkg;

  // Token kinds passed from the decoder to the encoder
  typedef enum logic [1:0] {
    TK_CP    = 2'd0,
    TK_OPEN  = 2'd1,
    TK_CLOSE = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [20:0] cp;
  } tok_t;

  // Token queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // Characters
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [20:0] CTRL_MAX  = 21'h1f;
  localparam logic [20:0] ASCII_END = 21'h80;

  // Code points with a two-byte backslash escape
  function automatic logic is_esc2(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    if (cp[20:8] == 13'd0) begin
      case (cp[7:0])
        CH_BSLASH, CH_QUOTE, CH_SLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // Second byte of a two-byte escape
  function automatic logic [7:0] esc_letter(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_BS:   r = 8'h62;  // b
      CH_FF:   r = 8'h66;  // f
      CH_LF:   r = 8'h6e;  // n
      CH_CR:   r = 8'h72;  // r
      CH_TAB:  r = 8'h74;  // t
      default: r = c;      // backslash, quote, slash stand as they are
    endcase
    return r;
  endfunction

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else             r = 8'h57 + {4'd0, nib};
    return r;
  endfunction

endpackage

@@ hw/rtl/json_string_escaper_top.sv @@
// A decoded token passes the token queue, the token register and the output register
// before its first output byte appears. A four-entry token queue joins the two sides.
// The encoder gives one output byte per cycle while the output side is ready. The
// decoder takes one input byte per cycle while the token queue has room; each quote and
// each byte released from a broken or flushed UTF-8 sequence takes a step of its own.
// Reset: synchronous, active low; clears decoder state, queue, outputs and ascii_only.
module json_string_escaper_top
  import jse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_in,
  input  logic        in_last_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_out,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic ascii_only_r;
  logic q_push, q_not_full, q_pop, q_not_empty;
  tok_t q_tok, q_head;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, ascii_only_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_only_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      ascii_only_r <= pwdata[0];
    end
  end

  jse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_first_in  (in_first_in),
    .in_last_in   (in_last_in),
    .q_push       (q_push),
    .q_tok        (q_tok),
    .q_not_full   (q_not_full)
  );

  jse_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_tok),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (q_head)
  );

  jse_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ascii_only   (ascii_only_r),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_out (out_last_out)
  );

endmodule

@@ hw/rtl/jse_fifo.sv @@
module jse_fifo
  import jse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output tok_t head_tok
);

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign not_full  = (cnt_r < (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_tok  = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push && not_full) begin
      mem_r[wp_r] <= push_tok;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && not_full) wp_r <= wp_r + QAW'(1);
      if (pop && not_empty) rp_r <= rp_r + QAW'(1);
      case ({push && not_full, pop && not_empty})
        2'b10:   cnt_r <= cnt_r + (QAW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QAW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/jse_front.sv @@
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_in,
  input  logic       in_last_in,
  output logic       q_push,
  output tok_t       q_tok,
  input  logic       q_not_full
);

  typedef enum logic [1:0] {
    PH_OPEN  = 2'd0,
    PH_BYTE  = 2'd1,
    PH_FLUSH = 2'd2
  } phase_t;

  // Current request
  logic        busy_r, busy_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  phase_t      phase_r, phase_nxt;
  // UTF-8 decoder
  logic        drain_r, drain_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  exp_r, exp_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        cont_ok, byte_done, finish;
  logic [7:0]  lo, hi;
  logic [20:0] acc_ext;

  // Continuation byte range, tighter after some lead bytes
  always_comb begin
    lo = 8'h80;
    hi = 8'hbf;
    if (cnt_r == 2'd1) begin
      case (held_r[0])
        8'he0:   lo = 8'ha0;
        8'hed:   hi = 8'h9f;
        8'hf0:   lo = 8'h90;
        8'hf4:   hi = 8'h8f;
        default: ;
      endcase
    end
    cont_ok = (byte_r >= lo) && (byte_r <= hi);
    acc_ext = {acc_r[14:0], byte_r[5:0]};
  end

  assign in_ready = !busy_r || finish;

  // Step the decoder, one token per cycle at most
  always_comb begin
    busy_nxt  = busy_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    drain_nxt = drain_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    exp_nxt   = exp_r;
    acc_nxt   = acc_r;
    q_push    = 1'b0;
    q_tok     = '{kind: TK_CP, cp: 21'd0};
    byte_done = 1'b0;
    finish    = 1'b0;

    if (busy_r && q_not_full) begin
      case (phase_r)
        PH_OPEN: begin
          q_push     = 1'b1;
          q_tok.kind = TK_OPEN;
          cnt_nxt    = 2'd0;
          exp_nxt    = 3'd0;
          acc_nxt    = 21'd0;
          drain_nxt  = 1'b0;
          phase_nxt  = PH_BYTE;
        end
        PH_BYTE: begin
          if (drain_r || (cnt_r != 2'd0 && !cont_ok)) begin
            // broken sequence: held bytes go out one by one as Latin-1
            q_push      = 1'b1;
            q_tok.cp    = {13'd0, held_r[0]};
            held_nxt[0] = held_r[1];
            held_nxt[1] = held_r[2];
            cnt_nxt     = cnt_r - 2'd1;
            drain_nxt   = (cnt_r > 2'd1);
          end else if (cnt_r == 2'd0) begin
            byte_done = 1'b1;
            if (byte_r >= 8'hc2 && byte_r <= 8'hf4) begin
              held_nxt[0] = byte_r;
              cnt_nxt     = 2'd1;
              if (byte_r <= 8'hdf) begin
                exp_nxt = 3'd2;
                acc_nxt = {16'd0, byte_r[4:0]};
              end else if (byte_r <= 8'hef) begin
                exp_nxt = 3'd3;
                acc_nxt = {17'd0, byte_r[3:0]};
              end else begin
                exp_nxt = 3'd4;
                acc_nxt = {18'd0, byte_r[2:0]};
              end
            end else begin
              q_push   = 1'b1;
              q_tok.cp = {13'd0, byte_r};
            end
          end else begin
            byte_done = 1'b1;
            if ({1'b0, cnt_r} + 3'd1 >= exp_r) begin
              q_push   = 1'b1;
              q_tok.cp = acc_ext;
              cnt_nxt  = 2'd0;
              exp_nxt  = 3'd0;
              acc_nxt  = 21'd0;
            end else begin
              held_nxt[cnt_r] = byte_r;
              cnt_nxt         = cnt_r + 2'd1;
              acc_nxt         = acc_ext;
            end
          end
          if (byte_done) begin
            if (last_r) phase_nxt = PH_FLUSH;
            else        finish    = 1'b1;
          end
        end
        PH_FLUSH: begin
          q_push = 1'b1;
          if (cnt_r != 2'd0) begin
            q_tok.cp    = {13'd0, held_r[0]};
            held_nxt[0] = held_r[1];
            held_nxt[1] = held_r[2];
            cnt_nxt     = cnt_r - 2'd1;
            drain_nxt   = 1'b0;
          end else begin
            q_tok.kind = TK_CLOSE;
            finish     = 1'b1;
          end
        end
        default: finish = 1'b1;
      endcase
    end

    if (finish) busy_nxt = 1'b0;

    // Take a new request
    if (in_valid && in_ready) begin
      busy_nxt  = 1'b1;
      byte_nxt  = in_data_byte;
      last_nxt  = in_last_in;
      phase_nxt = in_first_in ? PH_OPEN : PH_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_BYTE;
      drain_r <= 1'b0;
      cnt_r   <= 2'd0;
      exp_r   <= 3'd0;
      acc_r   <= 21'd0;
      held_r  <= '{default: 8'd0};
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      drain_r <= drain_nxt;
      cnt_r   <= cnt_nxt;
      exp_r   <= exp_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

@@ hw/rtl/jse_back.sv @@
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ascii_only,
  input  logic       q_not_empty,
  input  tok_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_out
);

  typedef enum logic [1:0] {
    M_QUOTE = 2'd0,
    M_ESC   = 2'd1,
    M_HEX   = 2'd2,
    M_UTF   = 2'd3
  } mode_t;

  // Token under expansion
  logic        tv_r;
  mode_t       mode_r;
  logic [20:0] cp_r;
  logic        close_r;
  logic [3:0]  len_r;
  logic [2:0]  idx_r;
  // Output register
  logic        ov_r;
  logic [7:0]  ob_r;
  logic        ol_r;

  logic        adv, last_idx, load;
  mode_t       mode_c;
  logic [3:0]  len_c;
  logic [7:0]  byte_c;
  logic [3:0]  pos;
  logic [23:0] cp_pad;

  assign adv      = tv_r && (!ov_r || out_ready);
  assign last_idx = ({1'b0, idx_r} == len_r - 4'd1);
  assign load     = q_not_empty && (!tv_r || (adv && last_idx));
  assign q_pop    = load;

  assign out_valid    = ov_r;
  assign out_byte     = ob_r;
  assign out_last_out = ol_r;

  // Classify the queue head
  always_comb begin
    mode_c = M_UTF;
    len_c  = 4'd1;
    if (q_head.kind != TK_CP) begin
      mode_c = M_QUOTE;
      len_c  = 4'd1;
    end else if (is_esc2(q_head.cp)) begin
      mode_c = M_ESC;
      len_c  = 4'd2;
    end else if (q_head.cp <= CTRL_MAX || (q_head.cp >= ASCII_END && ascii_only)) begin
      mode_c = M_HEX;
      if (q_head.cp[20])         len_c = 4'd8;
      else if (q_head.cp[19:16] != 4'd0) len_c = 4'd7;
      else                       len_c = 4'd6;
    end else if (q_head.cp < 21'h80) begin
      len_c = 4'd1;
    end else if (q_head.cp < 21'h800) begin
      len_c = 4'd2;
    end else if (q_head.cp < 21'h10000) begin
      len_c = 4'd3;
    end else begin
      len_c = 4'd4;
    end
  end

  // Byte at the current index
  always_comb begin
    pos    = len_r - 4'd1 - {1'b0, idx_r};
    cp_pad = {3'd0, cp_r};
    byte_c = CH_QUOTE;
    case (mode_r)
      M_QUOTE: byte_c = CH_QUOTE;
      M_ESC:   byte_c = (idx_r == 3'd0) ? CH_BSLASH : esc_letter(cp_r[7:0]);
      M_HEX: begin
        if (idx_r == 3'd0)      byte_c = CH_BSLASH;
        else if (idx_r == 3'd1) byte_c = CH_LOW_U;
        else                    byte_c = hex_char(cp_pad[{pos[2:0], 2'b00} +: 4]);
      end
      M_UTF: begin
        if (len_r == 4'd1) begin
          byte_c = cp_r[7:0];
        end else if (idx_r == 3'd0) begin
          case (len_r)
            4'd2:    byte_c = {3'b110, cp_r[10:6]};
            4'd3:    byte_c = {4'b1110, cp_r[15:12]};
            default: byte_c = {5'b11110, cp_r[20:18]};
          endcase
        end else begin
          case (pos[1:0])
            2'd0:    byte_c = {2'b10, cp_r[5:0]};
            2'd1:    byte_c = {2'b10, cp_r[11:6]};
            default: byte_c = {2'b10, cp_r[17:12]};
          endcase
        end
      end
      default: byte_c = CH_QUOTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r  <= 1'b0;
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      // token register
      if (load) begin
        tv_r  <= 1'b1;
        idx_r <= 3'd0;
      end else if (adv) begin
        if (last_idx) tv_r <= 1'b0;
        idx_r <= idx_r + 3'd1;
      end
      // output register
      if (adv)            ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (load) begin
      mode_r  <= mode_c;
      len_r   <= len_c;
      cp_r    <= q_head.cp;
      close_r <= (q_head.kind == TK_CLOSE);
    end
    if (adv) begin
      ob_r <= byte_c;
      ol_r <= close_r;
    end
  end

endmodule
